// ===== sv/mwsfe_pkg.sv =====
// Shared constants, types and tables of the mecanum wheel speed frame encoder.
`default_nettype none

package mwsfe_pkg;

    // Field widths of the command and of the frame byte stream.
    localparam int VEL_W     = 12;
    localparam int ARM_W     = 8;
    localparam int BYTE_W    = 8;
    localparam int SLOT_W    = 2;
    localparam int POS_W     = 4;
    localparam int NUM_WHEELS = 4;

    localparam logic [ARM_W-1:0] ARM_FACTOR_RESET = 8'd20;
    localparam int FIFO_DEPTH_DEFAULT = 4;

    // Scaling v * 45000 / 157 is split into v * 286 + floor(v * 98 / 157).
    localparam int SCALE_NUM  = 45000;
    localparam int SCALE_DEN  = 157;
    localparam int SCALE_INT  = SCALE_NUM / SCALE_DEN;
    localparam int SCALE_FRAC = SCALE_NUM % SCALE_DEN;

    // Internal widths: mixed speeds stay below 2^20 in magnitude.
    localparam int RK_W    = 21;
    localparam int MIX_W   = 22;
    localparam int MAG_W   = 20;
    localparam int P_W     = 28;
    localparam int N_W     = 26;
    localparam int Q_W     = 19;
    localparam int SUM_W   = 29;
    localparam int SPEED_W = 32;

    // floor(n / 157) for n < 2^26 is (n * RECIP) >> 34 with RECIP rounded up.
    localparam int RECIP_SHIFT = N_W + 8;
    localparam int RECIP_W     = 27;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(SCALE_DEN) - 64'd1) / 64'(SCALE_DEN);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int PROD_W = N_W + RECIP_W;

    // Frame layout.
    localparam logic [BYTE_W-1:0] HDR_SYNC0 = 8'h3E;
    localparam logic [BYTE_W-1:0] HDR_SYNC1 = 8'hA2;
    localparam logic [BYTE_W-1:0] HDR_LEN   = 8'h04;

    localparam logic [POS_W-1:0] POS_SYNC0 = 4'd0;
    localparam logic [POS_W-1:0] POS_SYNC1 = 4'd1;
    localparam logic [POS_W-1:0] POS_ID    = 4'd2;
    localparam logic [POS_W-1:0] POS_LEN   = 4'd3;
    localparam logic [POS_W-1:0] POS_HSUM  = 4'd4;
    localparam logic [POS_W-1:0] POS_D0    = 4'd5;
    localparam logic [POS_W-1:0] POS_D1    = 4'd6;
    localparam logic [POS_W-1:0] POS_D2    = 4'd7;
    localparam logic [POS_W-1:0] POS_D3    = 4'd8;
    localparam logic [POS_W-1:0] POS_DSUM  = 4'd9;

    localparam logic [SLOT_W-1:0] SLOT_LAST = 2'd3;

    // Wheel id sent in each of the four frames, in frame order.
    localparam logic [BYTE_W-1:0] SLOT_ID [NUM_WHEELS] = '{8'd2, 8'd4, 8'd1, 8'd3};

    // The four scaled wheel speeds of one command, by frame slot.
    typedef logic [NUM_WHEELS-1:0][SPEED_W-1:0] t_speed_set;

    // Head of the speed queue as seen by the frame serializer.
    typedef struct packed {
        logic       valid;
        t_speed_set data;
    } t_queue_head;

endpackage

`default_nettype wire

// ===== sv/mecanum_wheel_speed_frame_encoder_unit.sv =====
// Top level of the mecanum wheel speed frame encoder: command in, motor frame bytes out.
`default_nettype none

// Each accepted velocity command (x, y, rotation) is mixed into four wheel speeds
// with the arm factor k: x-y-rot*k, x+y-rot*k, x-y+rot*k and x+y+rot*k, sent to
// wheels 2, 4, 1 and 3, the first two negated. Each speed is scaled to
// trunc(v * 45000 / 157) toward zero and sent as a 10-byte frame: 3E, A2, wheel id,
// 04, header checksum, the 32-bit speed little-endian and a checksum over those four
// bytes. A command thus yields a 40-byte burst on the output stream; tuser tags every
// byte with its frame slot and position and tlast marks the final byte. The output
// stream carries one byte per cycle while m_axis_tready is high, so a steady flow of
// commands is paced by the byte serializer; commands arriving faster wait in the speed
// queue (FIFO_DEPTH entries) and the input stalls once the queue entries and the
// commands in the scaling pipeline together reach FIFO_DEPTH, while the scaling
// pipeline keeps taking requests back to back until then. The arm factor is written
// through the configuration port and should only be changed while the block is idle.
module mecanum_wheel_speed_frame_encoder_unit #(
    parameter int FIFO_DEPTH = mwsfe_pkg::FIFO_DEPTH_DEFAULT  // speed queue entries, 2..16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,

    // Velocity command requests.
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire  [39:0]                    s_axis_tdata,   // vel_x, vel_y, vel_rot, 4'b0

    // Motor frame bytes.
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // tx_byte
    output logic [5:0]                     m_axis_tuser,   // wheel_slot, byte_pos
    output logic                           m_axis_tlast,

    // Arm factor register.
    input  wire                            i_cfg_wr_en,
    input  wire  [mwsfe_pkg::ARM_W-1:0]    i_cfg_wr_data
);

    // Counts queue entries plus commands still in the scaling pipeline, so the
    // pipeline never has to stall: a request is only taken when its slot is free.
    localparam int USED_W = $clog2(FIFO_DEPTH + 1);

    logic [mwsfe_pkg::ARM_W-1:0]  r_arm_factor;
    logic [USED_W-1:0]            r_used;
    logic [USED_W-1:0]            n_used;

    logic                         accept;
    logic                         scale_valid;
    mwsfe_pkg::t_speed_set        scale_speeds;
    mwsfe_pkg::t_queue_head       queue_head;
    logic                         queue_pop;
    logic [mwsfe_pkg::SLOT_W-1:0] out_slot;
    logic [mwsfe_pkg::POS_W-1:0]  out_pos;

    assign s_axis_tready = (r_used != USED_W'(FIFO_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_used = r_used;
        if (accept && !queue_pop) begin
            n_used = r_used + USED_W'(1);
        end else if (!accept && queue_pop) begin
            n_used = r_used - USED_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_factor <= mwsfe_pkg::ARM_FACTOR_RESET;
            r_used       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_arm_factor <= i_cfg_wr_data;
            end
            r_used <= n_used;
        end
    end

    mwsfe_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_vel_x      (s_axis_tdata[11:0]),
        .i_vel_y      (s_axis_tdata[23:12]),
        .i_vel_rot    (s_axis_tdata[35:24]),
        .i_arm_factor (r_arm_factor),
        .o_valid      (scale_valid),
        .o_speeds     (scale_speeds)
    );

    mwsfe_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (scale_valid),
        .i_data  (scale_speeds),
        .i_pop   (queue_pop),
        .o_head  (queue_head)
    );

    mwsfe_serializer u_serializer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (queue_head),
        .o_pop   (queue_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_slot  (out_slot),
        .o_pos   (out_pos),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tuser = {out_pos, out_slot};

    // The credit count covers every command between the input and the serializer.
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(FIFO_DEPTH))
        else $error("more commands in flight than the speed queue can hold");

endmodule

`default_nettype wire

// ===== sv/mwsfe_scale.sv =====
// Front pipeline: mixes a velocity command into four wheel speeds and scales them.
`default_nettype none

module mwsfe_scale (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    input  wire signed [mwsfe_pkg::VEL_W-1:0]     i_vel_x,
    input  wire signed [mwsfe_pkg::VEL_W-1:0]     i_vel_y,
    input  wire signed [mwsfe_pkg::VEL_W-1:0]     i_vel_rot,
    input  wire        [mwsfe_pkg::ARM_W-1:0]     i_arm_factor,
    output logic                                  o_valid,
    output mwsfe_pkg::t_speed_set                 o_speeds
);

    localparam int NW = mwsfe_pkg::NUM_WHEELS;

    // Stage 1: rotation times arm factor.
    logic                                   r1_valid;
    logic signed [mwsfe_pkg::VEL_W-1:0]     r1_x, r1_y;
    logic signed [mwsfe_pkg::RK_W-1:0]      r1_rk;
    logic signed [mwsfe_pkg::RK_W-1:0]      rk_full;

    // Stage 2: sign and magnitude of the four mixed speeds.
    logic                                   r2_valid;
    logic [NW-1:0]                          r2_neg;
    logic [NW-1:0][mwsfe_pkg::MAG_W-1:0]    r2_mag;
    logic signed [mwsfe_pkg::MIX_W-1:0]     mix [NW];
    logic signed [mwsfe_pkg::MIX_W-1:0]     diff_xy, sum_xy, rk_ext;

    // Stage 3: integer part and fractional numerator of the scale.
    logic                                   r3_valid;
    logic [NW-1:0]                          r3_neg;
    logic [NW-1:0][mwsfe_pkg::P_W-1:0]      r3_p;
    logic [NW-1:0][mwsfe_pkg::N_W-1:0]      r3_n;

    // Stage 4: division of the fractional numerator by the denominator.
    logic                                   r4_valid;
    logic [NW-1:0]                          r4_neg;
    logic [NW-1:0][mwsfe_pkg::P_W-1:0]      r4_p;
    logic [NW-1:0][mwsfe_pkg::Q_W-1:0]      r4_q;
    logic [NW-1:0][mwsfe_pkg::PROD_W-1:0]   prod;

    // Stage 5: magnitude sum; the sign is applied on the way into the queue.
    logic                                   r5_valid;
    logic [NW-1:0]                          r5_neg;
    logic [NW-1:0][mwsfe_pkg::SUM_W-1:0]    r5_sum;

    assign rk_full = $signed({{(mwsfe_pkg::RK_W - mwsfe_pkg::VEL_W){i_vel_rot[mwsfe_pkg::VEL_W-1]}},
                              i_vel_rot})
                   * $signed({{(mwsfe_pkg::RK_W - mwsfe_pkg::ARM_W){1'b0}}, i_arm_factor});

    assign diff_xy = $signed({{(mwsfe_pkg::MIX_W - mwsfe_pkg::VEL_W){r1_x[mwsfe_pkg::VEL_W-1]}}, r1_x})
                   - $signed({{(mwsfe_pkg::MIX_W - mwsfe_pkg::VEL_W){r1_y[mwsfe_pkg::VEL_W-1]}}, r1_y});
    assign sum_xy  = $signed({{(mwsfe_pkg::MIX_W - mwsfe_pkg::VEL_W){r1_x[mwsfe_pkg::VEL_W-1]}}, r1_x})
                   + $signed({{(mwsfe_pkg::MIX_W - mwsfe_pkg::VEL_W){r1_y[mwsfe_pkg::VEL_W-1]}}, r1_y});
    assign rk_ext  = $signed({{(mwsfe_pkg::MIX_W - mwsfe_pkg::RK_W){r1_rk[mwsfe_pkg::RK_W-1]}}, r1_rk});

    // The first two wheels are mounted mirrored, so their speeds are negated.
    assign mix[0] = rk_ext - diff_xy;
    assign mix[1] = rk_ext - sum_xy;
    assign mix[2] = diff_xy + rk_ext;
    assign mix[3] = sum_xy + rk_ext;

    always_comb begin
        for (int i = 0; i < NW; i++) begin
            prod[i] = mwsfe_pkg::PROD_W'(r3_n[i]) * mwsfe_pkg::PROD_W'(mwsfe_pkg::RECIP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_x  <= i_vel_x;
        r1_y  <= i_vel_y;
        r1_rk <= rk_full;
        for (int i = 0; i < NW; i++) begin
            r2_neg[i] <= mix[i][mwsfe_pkg::MIX_W-1];
            r2_mag[i] <= mix[i][mwsfe_pkg::MIX_W-1] ? mwsfe_pkg::MAG_W'(-mix[i])
                                                     : mwsfe_pkg::MAG_W'(mix[i]);
            r3_neg[i] <= r2_neg[i];
            r3_p[i]   <= mwsfe_pkg::P_W'(r2_mag[i]) * mwsfe_pkg::P_W'(mwsfe_pkg::SCALE_INT);
            r3_n[i]   <= mwsfe_pkg::N_W'(r2_mag[i]) * mwsfe_pkg::N_W'(mwsfe_pkg::SCALE_FRAC);
            r4_neg[i] <= r3_neg[i];
            r4_p[i]   <= r3_p[i];
            r4_q[i]   <= prod[i][mwsfe_pkg::RECIP_SHIFT +: mwsfe_pkg::Q_W];
            r5_neg[i] <= r4_neg[i];
            r5_sum[i] <= mwsfe_pkg::SUM_W'(r4_p[i]) + mwsfe_pkg::SUM_W'(r4_q[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < NW; i++) begin
            o_speeds[i] = r5_neg[i] ? mwsfe_pkg::SPEED_W'(0) - mwsfe_pkg::SPEED_W'(r5_sum[i])
                                    : mwsfe_pkg::SPEED_W'(r5_sum[i]);
        end
    end

    assign o_valid = r5_valid;

    // A command leaves the pipeline only after passing through each of its stage registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r5_valid |-> $past(i_valid, 5))
        else $error("scale pipeline produced a result without a matching request");

endmodule

`default_nettype wire

// ===== sv/mwsfe_fifo.sv =====
// Short queue of scaled speed sets between the scaling pipeline and the serializer.
`default_nettype none

module mwsfe_fifo #(
    parameter int DEPTH = mwsfe_pkg::FIFO_DEPTH_DEFAULT
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_push,
    input  wire mwsfe_pkg::t_speed_set   i_data,
    input  wire                          i_pop,
    output mwsfe_pkg::t_queue_head       o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mwsfe_pkg::t_speed_set r_mem [DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]      r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.data  = r_mem[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CNT_W'(DEPTH)) || i_pop)
        else $error("speed queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("speed queue read while empty");

endmodule

`default_nettype wire

// ===== sv/mwsfe_serializer.sv =====
// Back end: turns one speed set into four 10-byte motor frames, one byte a cycle while the output is ready.
`default_nettype none

module mwsfe_serializer (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire mwsfe_pkg::t_queue_head       i_head,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire                               i_ready,
    output logic [mwsfe_pkg::BYTE_W-1:0]      o_byte,
    output logic [mwsfe_pkg::SLOT_W-1:0]      o_slot,
    output logic [mwsfe_pkg::POS_W-1:0]       o_pos,
    output logic                              o_last
);

    logic                               r_busy;
    logic [mwsfe_pkg::SLOT_W-1:0]       r_slot;
    logic [mwsfe_pkg::POS_W-1:0]        r_pos;
    mwsfe_pkg::t_speed_set              r_words;
    logic [mwsfe_pkg::BYTE_W-1:0]       r_sum;

    logic                               r_out_valid;
    logic [mwsfe_pkg::BYTE_W-1:0]       r_out_byte;
    logic [mwsfe_pkg::SLOT_W-1:0]       r_out_slot;
    logic [mwsfe_pkg::POS_W-1:0]        r_out_pos;
    logic                               r_out_last;

    logic                               advance;
    logic                               end_burst;
    logic                               load;
    logic [mwsfe_pkg::SPEED_W-1:0]      word;
    logic [mwsfe_pkg::BYTE_W-1:0]       wheel_id;
    logic [mwsfe_pkg::BYTE_W-1:0]       cur_byte;

    assign advance   = r_busy && (!r_out_valid || i_ready);
    assign end_burst = (r_slot == mwsfe_pkg::SLOT_LAST) && (r_pos == mwsfe_pkg::POS_DSUM);
    assign load      = i_head.valid && (!r_busy || (advance && end_burst));
    assign o_pop     = load;

    assign word     = r_words[r_slot];
    assign wheel_id = mwsfe_pkg::SLOT_ID[r_slot];

    always_comb begin
        unique case (r_pos)
            mwsfe_pkg::POS_SYNC0: cur_byte = mwsfe_pkg::HDR_SYNC0;
            mwsfe_pkg::POS_SYNC1: cur_byte = mwsfe_pkg::HDR_SYNC1;
            mwsfe_pkg::POS_ID:    cur_byte = wheel_id;
            mwsfe_pkg::POS_LEN:   cur_byte = mwsfe_pkg::HDR_LEN;
            mwsfe_pkg::POS_HSUM:  cur_byte = mwsfe_pkg::HDR_SYNC0 + mwsfe_pkg::HDR_SYNC1
                                           + mwsfe_pkg::HDR_LEN + wheel_id;
            mwsfe_pkg::POS_D0:    cur_byte = word[7:0];
            mwsfe_pkg::POS_D1:    cur_byte = word[15:8];
            mwsfe_pkg::POS_D2:    cur_byte = word[23:16];
            mwsfe_pkg::POS_D3:    cur_byte = word[31:24];
            mwsfe_pkg::POS_DSUM:  cur_byte = r_sum;
            default:              cur_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_slot      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_slot <= '0;
                r_pos  <= '0;
            end else if (advance && end_burst) begin
                r_busy <= 1'b0;
            end else if (advance) begin
                if (r_pos == mwsfe_pkg::POS_DSUM) begin
                    r_pos  <= '0;
                    r_slot <= r_slot + mwsfe_pkg::SLOT_W'(1);
                end else begin
                    r_pos <= r_pos + mwsfe_pkg::POS_W'(1);
                end
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_words <= i_head.data;
        end
        if (advance) begin
            r_out_byte <= cur_byte;
            r_out_slot <= r_slot;
            r_out_pos  <= r_pos;
            r_out_last <= end_burst;
            case (r_pos) inside
                mwsfe_pkg::POS_D0:                                         r_sum <= cur_byte;
                mwsfe_pkg::POS_D1, mwsfe_pkg::POS_D2, mwsfe_pkg::POS_D3:   r_sum <= r_sum + cur_byte;
                default:                                                   r_sum <= r_sum;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_slot  = r_out_slot;
    assign o_pos   = r_out_pos;
    assign o_last  = r_out_last;

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_slot == mwsfe_pkg::SLOT_LAST)
                                     && (r_out_pos == mwsfe_pkg::POS_DSUM))
        else $error("burst end flagged away from the final checksum byte");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> !r_busy || end_burst)
        else $error("new speed set loaded in the middle of a burst");

endmodule

`default_nettype wire
